// File: sv/kdq_pkg.sv
`default_nettype none
package kdq_pkg;

	localparam int DEPTH = 16;
	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int KEY_W = 32;
	localparam int VAL_W = 32;
	localparam int KIND_W = 3;
	localparam int STATUS_W = 2;

	localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd0;
	localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 3'd1;
	localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd2;
	localparam logic [KIND_W-1:0] KIND_POP_BACK   = 3'd3;
	localparam logic [KIND_W-1:0] KIND_ERASE      = 3'd4;
	localparam logic [KIND_W-1:0] KIND_QUERY      = 3'd5;

	localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

	typedef enum logic [2:0] {
		CELL_HOLD       = 3'd0,
		CELL_LOAD       = 3'd1,
		CELL_TAKE_LEFT  = 3'd2,
		CELL_TAKE_RIGHT = 3'd3,
		CELL_MARK       = 3'd4,
		CELL_COMPACT    = 3'd5
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		logic     live;
	} cell_ctl_t;

	typedef struct packed {
		logic [STATUS_W-1:0]    status;
		logic [CNT_W-1:0]       entry_count;
		logic [CNT_W-1:0]       removed_count;
		logic signed [KEY_W-1:0] front_key;
		logic [VAL_W-1:0]       front_value;
		logic signed [KEY_W-1:0] back_key;
		logic [VAL_W-1:0]       back_value;
	} res_t;

endpackage
`default_nettype wire

// File: sv/keyed_double_ended_queue.sv
`default_nettype none
// Bounded double-ended queue of kdq_pkg::DEPTH entries (signed 32-bit key plus an opaque
// 32-bit value), built as a row of cells where cell 0 holds the front entry. Each input
// transaction pushes at either end, pops either end, erases every entry with a given key
// (survivors keep their order), or just queries; each returns exactly one result
// transaction with status, entry count, removed count and the front/back entries (zeros
// when empty). Push, pop and query update the cells, where they change, on acceptance;
// the report is captured in the state after that. Erase on a non-empty queue runs a mark
// step, a tally step, DEPTH compaction steps in which holes bubble toward the back through
// neighbor swaps, then the report. in_stall is high while a transaction is in flight and
// when the two-entry result queue is full, so one new transaction can be taken while a
// finished result still waits.
module keyed_double_ended_queue (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  in_valid,
	output logic                                       in_stall,
	input  wire logic [kdq_pkg::KIND_W-1:0]            kind,
	input  wire logic signed [kdq_pkg::KEY_W-1:0]      item_key,
	input  wire logic [kdq_pkg::VAL_W-1:0]             item_value,
	output logic                                       out_valid,
	input  wire logic                                  out_stall,
	output logic [kdq_pkg::STATUS_W-1:0]               status,
	output logic [kdq_pkg::CNT_W-1:0]                  entry_count,
	output logic [kdq_pkg::CNT_W-1:0]                  removed_count,
	output logic signed [kdq_pkg::KEY_W-1:0]           front_key,
	output logic [kdq_pkg::VAL_W-1:0]                  front_value,
	output logic signed [kdq_pkg::KEY_W-1:0]           back_key,
	output logic [kdq_pkg::VAL_W-1:0]                  back_value
);

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_ERASE  = 3'b010,
		ST_REPORT = 3'b100
	} state_t;

	state_t                          state_q;
	logic [kdq_pkg::CNT_W-1:0]       count_q;
	logic [kdq_pkg::CNT_W-1:0]       step_q;
	logic [kdq_pkg::CNT_W-1:0]       removed_q;
	logic [kdq_pkg::STATUS_W-1:0]    status_q;
	logic [kdq_pkg::DEPTH-1:0]       tally_q;

	logic                            accept;
	logic                            q_full;
	logic                            is_empty;
	logic                            is_full;
	logic [kdq_pkg::CNT_W-1:0]       removed_nx;
	logic [kdq_pkg::IDX_W-1:0]       back_idx;
	kdq_pkg::res_t                   res;
	kdq_pkg::res_t                   res_out;

	kdq_pkg::cell_ctl_t              ctl [kdq_pkg::DEPTH];
	logic signed [kdq_pkg::KEY_W-1:0] cell_key [kdq_pkg::DEPTH];
	logic [kdq_pkg::VAL_W-1:0]       cell_value [kdq_pkg::DEPTH];
	logic [kdq_pkg::DEPTH-1:0]       cell_mark;
	logic [kdq_pkg::DEPTH-1:0]       live;

	assign in_stall = (state_q != ST_IDLE) || q_full;
	assign accept   = in_valid && !in_stall;
	assign is_empty = (count_q == '0);
	assign is_full  = (count_q == kdq_pkg::CNT_W'(kdq_pkg::DEPTH));

	// removed tally includes the bit shifted out this cycle
	assign removed_nx = removed_q + kdq_pkg::CNT_W'(tally_q[0]);

	// per-cell command decode
	always_comb begin
		for (int i = 0; i < kdq_pkg::DEPTH; i++) begin
			live[i]    = (kdq_pkg::CNT_W'(i) < count_q);
			ctl[i].live = live[i];
			ctl[i].op  = kdq_pkg::CELL_HOLD;
			if (accept) begin
				unique case (kind)
					kdq_pkg::KIND_PUSH_FRONT: begin
						if (!is_full) begin
							ctl[i].op = (i == 0) ? kdq_pkg::CELL_LOAD
								: kdq_pkg::CELL_TAKE_LEFT;
						end
					end
					kdq_pkg::KIND_PUSH_BACK: begin
						if (!is_full && (count_q == kdq_pkg::CNT_W'(i))) begin
							ctl[i].op = kdq_pkg::CELL_LOAD;
						end
					end
					kdq_pkg::KIND_POP_FRONT: begin
						if (!is_empty) begin
							ctl[i].op = kdq_pkg::CELL_TAKE_RIGHT;
						end
					end
					kdq_pkg::KIND_ERASE: begin
						if (!is_empty) begin
							ctl[i].op = kdq_pkg::CELL_MARK;
						end
					end
					default: begin
					end
				endcase
			end else if (state_q == ST_ERASE && step_q != '0) begin
				ctl[i].op = kdq_pkg::CELL_COMPACT;
			end
		end
	end

	// the row of cells; the ends tie off with no hole on the left, a hole on the right
	for (genvar g = 0; g < kdq_pkg::DEPTH; g++) begin : g_cell
		localparam int L = (g == 0) ? 0 : g - 1;
		localparam int R = (g == kdq_pkg::DEPTH - 1) ? g : g + 1;

		kdq_cell u_cell (
			.clk         (clk),
			.ctl         (ctl[g]),
			.item_key    (item_key),
			.item_value  (item_value),
			.left_key    (cell_key[L]),
			.left_value  (cell_value[L]),
			.left_mark   ((g == 0) ? 1'b0 : cell_mark[L]),
			.right_key   (cell_key[R]),
			.right_value (cell_value[R]),
			.right_mark  ((g == kdq_pkg::DEPTH - 1) ? 1'b1 : cell_mark[R]),
			.key         (cell_key[g]),
			.value       (cell_value[g]),
			.mark        (cell_mark[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			count_q   <= '0;
			step_q    <= '0;
			removed_q <= '0;
			status_q  <= kdq_pkg::STATUS_OK;
			tally_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q   <= ST_REPORT;
						status_q  <= kdq_pkg::STATUS_OK;
						removed_q <= '0;
						unique case (kind) inside
							kdq_pkg::KIND_PUSH_FRONT,
							kdq_pkg::KIND_PUSH_BACK: begin
								if (is_full) begin
									status_q <= kdq_pkg::STATUS_FULL;
								end else begin
									count_q <= count_q + 1'b1;
								end
							end
							kdq_pkg::KIND_POP_FRONT,
							kdq_pkg::KIND_POP_BACK: begin
								if (is_empty) begin
									status_q <= kdq_pkg::STATUS_EMPTY;
								end else begin
									count_q   <= count_q - 1'b1;
									removed_q <= kdq_pkg::CNT_W'(1);
								end
							end
							kdq_pkg::KIND_ERASE: begin
								if (is_empty) begin
									status_q <= kdq_pkg::STATUS_EMPTY;
								end else begin
									state_q <= ST_ERASE;
									step_q  <= '0;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_ERASE: begin
					if (step_q == '0) begin
						// marks are fresh; count is still the pre-erase count
						tally_q <= cell_mark & live;
					end else begin
						tally_q   <= tally_q >> 1;
						removed_q <= removed_nx;
					end
					if (step_q == kdq_pkg::CNT_W'(kdq_pkg::DEPTH)) begin
						count_q <= count_q - removed_nx;
						state_q <= ST_REPORT;
					end
					step_q <= step_q + 1'b1;
				end
				ST_REPORT: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// report snapshot, taken once the cells have settled
	assign back_idx = kdq_pkg::IDX_W'(count_q - kdq_pkg::CNT_W'(1));

	always_comb begin
		res.status        = status_q;
		res.entry_count   = count_q;
		res.removed_count = removed_q;
		if (is_empty) begin
			res.front_key   = '0;
			res.front_value = '0;
			res.back_key    = '0;
			res.back_value  = '0;
		end else begin
			res.front_key   = cell_key[0];
			res.front_value = cell_value[0];
			res.back_key    = cell_key[back_idx];
			res.back_value  = cell_value[back_idx];
		end
	end

	kdq_res_queue u_res_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (state_q == ST_REPORT),
		.din       (res),
		.full      (q_full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.dout      (res_out)
	);

	assign status        = res_out.status;
	assign entry_count   = res_out.entry_count;
	assign removed_count = res_out.removed_count;
	assign front_key     = res_out.front_key;
	assign front_value   = res_out.front_value;
	assign back_key      = res_out.back_key;
	assign back_value    = res_out.back_value;

endmodule
`default_nettype wire

// File: sv/kdq_cell.sv
`default_nettype none
module kdq_cell (
	input  wire logic                            clk,
	input  wire kdq_pkg::cell_ctl_t              ctl,
	input  wire logic signed [kdq_pkg::KEY_W-1:0] item_key,
	input  wire logic [kdq_pkg::VAL_W-1:0]       item_value,
	input  wire logic signed [kdq_pkg::KEY_W-1:0] left_key,
	input  wire logic [kdq_pkg::VAL_W-1:0]       left_value,
	input  wire logic                            left_mark,
	input  wire logic signed [kdq_pkg::KEY_W-1:0] right_key,
	input  wire logic [kdq_pkg::VAL_W-1:0]       right_value,
	input  wire logic                            right_mark,
	output logic signed [kdq_pkg::KEY_W-1:0]      key,
	output logic [kdq_pkg::VAL_W-1:0]            value,
	output logic                                 mark
);

	logic signed [kdq_pkg::KEY_W-1:0] key_q;
	logic [kdq_pkg::VAL_W-1:0]        value_q;
	logic                             mark_q;

	always_ff @(posedge clk) begin
		unique case (ctl.op)
			kdq_pkg::CELL_LOAD: begin
				key_q   <= item_key;
				value_q <= item_value;
			end
			kdq_pkg::CELL_TAKE_LEFT: begin
				key_q   <= left_key;
				value_q <= left_value;
			end
			kdq_pkg::CELL_TAKE_RIGHT: begin
				key_q   <= right_key;
				value_q <= right_value;
			end
			kdq_pkg::CELL_MARK: begin
				// holes: dead slots and matching keys
				mark_q <= !ctl.live || (key_q == item_key);
			end
			kdq_pkg::CELL_COMPACT: begin
				// hole swaps with a kept neighbor on the right
				if (mark_q && !right_mark) begin
					key_q   <= right_key;
					value_q <= right_value;
					mark_q  <= 1'b0;
				end else if (!mark_q && left_mark) begin
					mark_q <= 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	assign key   = key_q;
	assign value = value_q;
	assign mark  = mark_q;

endmodule
`default_nettype wire

// File: sv/kdq_res_queue.sv
`default_nettype none
module kdq_res_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire kdq_pkg::res_t din,
	output logic               full,
	output logic               out_valid,
	input  wire logic          out_stall,
	output kdq_pkg::res_t      dout
);

	kdq_pkg::res_t ent0_q;
	kdq_pkg::res_t ent1_q;
	logic [1:0]    cnt_q;
	logic          pop;
	logic [1:0]    cnt_after_pop;

	assign out_valid     = (cnt_q != 2'd0);
	assign full          = (cnt_q == 2'd2);
	assign pop           = out_valid && !out_stall;
	assign cnt_after_pop = cnt_q - {1'b0, pop};
	assign dout          = ent0_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			cnt_q <= cnt_after_pop + {1'b0, push};
		end
	end

	always_ff @(posedge clk) begin
		if (push && (cnt_after_pop == 2'd0)) begin
			ent0_q <= din;
		end else if (pop) begin
			ent0_q <= ent1_q;
		end
		if (push && (cnt_after_pop != 2'd0)) begin
			ent1_q <= din;
		end
	end

endmodule
`default_nettype wire
